### hw/rtl/pft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants for the prime factor / totient block.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int IN_DATA_W   = 32;  // value
    localparam int PRIME_W     = 32;
    localparam int EXP_W       = 5;
    localparam int TOT_W       = 32;
    localparam int OUT_DATA_W  = 72;  // prime, exponent, totient, zero fill
    localparam int MAX_RESULTS = 9;
    localparam int RES_CNT_W   = 4;
    localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;
    localparam logic [TOT_W-1:0] TOT_MAX = 32'hFFFF_FFFF;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,    // take a new value
        OP_SHIFT2,  // divide out one factor of two
        OP_NEXT,    // step to the next trial divisor
        OP_DIV,     // start remaining / divisor
        OP_DIVOUT,  // remaining = quotient, bump count, start totient multiply
        OP_REST,    // leftover prime: start totient multiply
        OP_TAKE,    // retire a prime into the pending slot, emit the old one if due
        OP_FINAL    // emit the pending result as the last one
    } pft_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_EVEN,
        ST_TAKE_LOOP,
        ST_NEXT,
        ST_DIV,
        ST_DWAIT,
        ST_DIVOUT,
        ST_MWAIT,
        ST_REST_CHK,
        ST_RWAIT,
        ST_TAKE_REST,
        ST_FIN
    } pft_state_t;

    typedef struct packed {
        logic rem_le1;    // remaining <= 1
        logic rem_gt2;    // remaining > 2
        logic rem_odd;    // remaining is odd
        logic mult_zero;  // no factor of the divisor taken yet
        logic div_done;   // divider result ready this cycle
        logic div_ge;     // divisor <= quotient
        logic rem_zero;   // division remainder is zero
        logic mul_done;   // totient product written this cycle
        logic need_emit;  // taking a prime pushes out a result
        logic out_free;   // output register can be loaded
    } pft_status_t;

endpackage
`default_nettype wire

### hw/rtl/prime_factor_totient.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_factor_totient
// Trial-division factorization with Euler's totient, one result per prime (max 9).
// ----------------------------------------------------------------------------
//
//  channel | dir | bus fields (lsb first)
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tdata: value[31:0]
//  m_*     | out | tdata: prime[31:0] exponent[36:32] totient[68:37] zero[71:69];
//          |     | tlast: last result for this value
//
// One value at a time. Each odd trial divisor costs a division in the shared
// bit-serial divider; each factor taken out adds a division and a shift-add
// multiply, each factor of two a shift. A prime near 2^32 tries 32768 divisors.
// Reset is asynchronous and clears the sequencer and the output valid.
// A stalled m_tready holds the output register and blocks only a new result.
// ----------------------------------------------------------------------------
module prime_factor_totient #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input transactions
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pft_pkg::IN_DATA_W-1:0]     s_tdata,   // value[31:0]
    // result transactions
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [pft_pkg::OUT_DATA_W-1:0]    m_tdata,   // prime, exponent, totient
    output logic                                   m_tlast    // last
);
    import pft_pkg::*;

    pft_op_t     op;
    pft_status_t status;

    // sequencer: owns the input handshake, issues one datapath op per cycle
    pft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .op       (op)
    );

    // datapath: remaining value, divisor, totient product, pending result
    // and the output register that decouples the result channel
    pft_datapath #(.W(VALUE_WIDTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .value    (s_tdata),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

### hw/rtl/pft_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_div
// Restoring divider, one quotient bit per cycle; results hold after done.
// ----------------------------------------------------------------------------
module pft_div #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic      [W-1:0] quo,
    output logic      [W-1:0] rem,
    output logic              done
);
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[W-1]};
        diff      = rem_sh - {1'b0, den};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            quo_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### hw/rtl/pft_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_mul
// Shift-add multiplier, product truncated to W bits; ends when the
// multiplier runs out of set bits.
// ----------------------------------------------------------------------------
module pft_mul #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] prod,
    output logic              done
);
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W-1:0] mcand_reg, mcand_next;
    logic [W-1:0] mplier_reg, mplier_next;
    logic [W-1:0] prod_reg, prod_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            mcand_next  = a;
            mplier_next = b;
            prod_next   = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                prod_next = prod_reg + mcand_reg;
            mcand_next  = {mcand_reg[W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[W-1:1]};
            if (mplier_next == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### hw/rtl/pft_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_datapath
// Factoring registers, shared divider and multiplier, pending result slot
// and output register.
// ----------------------------------------------------------------------------
module pft_datapath #(
    parameter int W = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pft_pkg::pft_op_t                  op,
    input  wire logic [pft_pkg::IN_DATA_W-1:0]     value,
    output pft_pkg::pft_status_t                   status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [pft_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                   m_tlast
);
    import pft_pkg::*;

    localparam int CW = ($clog2(W + 1) > EXP_W) ? $clog2(W + 1) : EXP_W;
    localparam int XW = (W > TOT_W) ? W : TOT_W;

    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         d_reg, d_next;
    logic [CW-1:0]        mult_reg, mult_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         pend_prime_reg, pend_prime_next;
    logic [CW-1:0]        pend_exp_reg, pend_exp_next;
    logic                 have_pend_reg, have_pend_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PRIME_W-1:0]   out_prime_reg, out_prime_next;
    logic [EXP_W-1:0]     out_exp_reg, out_exp_next;
    logic [TOT_W-1:0]     out_tot_reg, out_tot_next;
    logic                 out_last_reg, out_last_next;

    logic [W-1:0]         val_w;
    logic [W-1:0]         div_quo, div_rem;
    logic                 div_done;
    logic [W-1:0]         mul_b, mul_prod;
    logic                 mul_done;
    logic                 out_free, need_emit;
    logic [XW-1:0]        prime_x, tot_x;
    logic [PRIME_W-1:0]   prime_fmt;
    logic [EXP_W-1:0]     exp_fmt;
    logic [TOT_W-1:0]     tot_fmt;

    assign val_w = W'(value);

    pft_div #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (op == OP_DIV),
        .num   (rem_reg),
        .den   (d_reg),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    // first factor of a prime contributes p-1, each further one p
    assign mul_b = (op == OP_REST) ? rem_reg - 1'b1
                 : (mult_reg == '0) ? d_reg - 1'b1 : d_reg;

    pft_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((op == OP_DIVOUT) || (op == OP_REST)),
        .a     (acc_reg),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign need_emit = have_pend_reg && (cnt_reg < RES_CNT_W'(MAX_RESULTS - 1));

    // result formatting: 32-bit prime, saturated exponent and totient
    assign prime_x   = XW'(pend_prime_reg);
    assign prime_fmt = prime_x[PRIME_W-1:0];
    assign exp_fmt   = (pend_exp_reg > CW'(EXP_MAX)) ? EXP_MAX : pend_exp_reg[EXP_W-1:0];
    assign tot_x     = XW'(acc_reg);
    assign tot_fmt   = (tot_x > XW'(TOT_MAX)) ? TOT_MAX : tot_x[TOT_W-1:0];

    always_comb
    begin
        rem_next        = rem_reg;
        d_next          = d_reg;
        mult_next       = mult_reg;
        acc_next        = acc_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        have_pend_next  = have_pend_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_prime_next  = out_prime_reg;
        out_exp_next    = out_exp_reg;
        out_tot_next    = out_tot_reg;
        out_last_next   = out_last_reg;

        if (mul_done)
            acc_next = mul_prod;

        unique case (op)
            OP_LOAD:
            begin
                rem_next        = val_w;
                d_next          = W'(2);
                mult_next       = '0;
                acc_next        = (val_w <= W'(1)) ? val_w : W'(1);
                pend_prime_next = '0;
                pend_exp_next   = '0;
                have_pend_next  = 1'b0;
                cnt_next        = '0;
            end
            OP_SHIFT2:
            begin
                rem_next  = {1'b0, rem_reg[W-1:1]};
                mult_next = mult_reg + 1'b1;
                if (mult_reg != '0)
                    acc_next = {acc_reg[W-2:0], 1'b0};
            end
            OP_NEXT:
            begin
                d_next    = (d_reg == W'(2)) ? W'(3) : d_reg + W'(2);
                mult_next = '0;
            end
            OP_DIVOUT:
            begin
                rem_next  = div_quo;
                mult_next = mult_reg + 1'b1;
            end
            OP_REST:
            begin
                d_next    = rem_reg;
                mult_next = CW'(1);
                rem_next  = W'(1);
            end
            OP_TAKE:
            begin
                if (need_emit)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_fmt;
                    out_exp_next   = exp_fmt;
                    out_tot_next   = '0;
                    out_last_next  = 1'b0;
                    cnt_next       = cnt_reg + 1'b1;
                end
                // past the result limit only the totient keeps growing
                if (!have_pend_reg || need_emit)
                begin
                    pend_prime_next = d_reg;
                    pend_exp_next   = mult_reg;
                    have_pend_next  = 1'b1;
                end
            end
            OP_FINAL:
            begin
                out_valid_next = 1'b1;
                out_prime_next = prime_fmt;
                out_exp_next   = exp_fmt;
                out_tot_next   = tot_fmt;
                out_last_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            have_pend_reg <= 1'b0;
            cnt_reg       <= '0;
            mult_reg      <= '0;
            rem_reg       <= '0;
            d_reg         <= W'(2);
            acc_reg       <= W'(1);
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            have_pend_reg <= have_pend_next;
            cnt_reg       <= cnt_next;
            mult_reg      <= mult_next;
            rem_reg       <= rem_next;
            d_reg         <= d_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
        out_prime_reg  <= out_prime_next;
        out_exp_reg    <= out_exp_next;
        out_tot_reg    <= out_tot_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        status.rem_le1   = rem_reg <= W'(1);
        status.rem_gt2   = rem_reg > W'(2);
        status.rem_odd   = rem_reg[0];
        status.mult_zero = mult_reg == '0;
        status.div_done  = div_done;
        status.div_ge    = d_reg <= div_quo;
        status.rem_zero  = div_rem == '0;
        status.mul_done  = mul_done;
        status.need_emit = need_emit;
        status.out_free  = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - PRIME_W - EXP_W - TOT_W){1'b0}},
                       out_tot_reg, out_exp_reg, out_prime_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### hw/rtl/pft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_ctrl
// Sequencer for trial division: twos, odd divisors, leftover prime, emit.
// ----------------------------------------------------------------------------
module pft_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pft_pkg::pft_status_t  status,
    output pft_pkg::pft_op_t           op
);
    import pft_pkg::*;

    pft_state_t state_reg, state_next;
    logic       take_ok;

    assign take_ok = !status.need_emit || status.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_CHK;
            ST_CHK:       state_next = status.rem_le1 ? ST_FIN : ST_EVEN;
            ST_EVEN:
            begin
                if (status.rem_odd)
                    state_next = status.mult_zero ? ST_NEXT : ST_TAKE_LOOP;
            end
            ST_TAKE_LOOP: if (take_ok) state_next = ST_NEXT;
            ST_NEXT:      state_next = ST_DIV;
            ST_DIV:       state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (status.div_done)
                begin
                    priority if (status.mult_zero && !status.div_ge)
                        state_next = ST_REST_CHK;
                    else if (status.rem_zero)
                        state_next = ST_DIVOUT;
                    else if (!status.mult_zero)
                        state_next = ST_TAKE_LOOP;
                    else
                        state_next = ST_NEXT;
                end
            end
            ST_DIVOUT:    state_next = ST_MWAIT;
            ST_MWAIT:     if (status.mul_done) state_next = ST_DIV;
            ST_REST_CHK:  state_next = status.rem_gt2 ? ST_RWAIT : ST_FIN;
            ST_RWAIT:     if (status.mul_done) state_next = ST_TAKE_REST;
            ST_TAKE_REST: if (take_ok) state_next = ST_FIN;
            ST_FIN:       if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op       = OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    op = OP_LOAD;
            end
            ST_EVEN:      if (!status.rem_odd) op = OP_SHIFT2;
            ST_TAKE_LOOP: if (take_ok) op = OP_TAKE;
            ST_TAKE_REST: if (take_ok) op = OP_TAKE;
            ST_NEXT:      op = OP_NEXT;
            ST_DIV:       op = OP_DIV;
            ST_DIVOUT:    op = OP_DIVOUT;
            ST_REST_CHK:  if (status.rem_gt2) op = OP_REST;
            ST_FIN:       if (status.out_free) op = OP_FINAL;
            default:      op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### hw/rtl/pft_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks for prime_factor_totient, bound to the top level.
// ----------------------------------------------------------------------------
module pft_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast
);
    // one value in flight: no new transaction right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // totient only rides on the last result
    a_tot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[68:37] == 32'd0))
        else $error("totient on a non-last result");

    // prime zero only for the single result of a trivial value
    a_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[31:0] == 32'd0)) |-> (m_tlast && (m_tdata[36:32] == 5'd0)))
        else $error("prime zero with exponent or not last");

endmodule

bind prime_factor_totient pft_checker u_pft_checker (.*);
`default_nettype wire

### dv/pft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_tb_checker
// Watches both stream channels of prime_factor_totient, predicts the prime
// list and totient for every accepted value and compares each result.
// ----------------------------------------------------------------------------
module pft_tb_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [pft_pkg::IN_DATA_W-1:0]    s_tdata,   // value[31:0]
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [pft_pkg::OUT_DATA_W-1:0]   m_tdata,   // prime, exponent, totient
    input  wire logic                             m_tlast,   // last
    output int                                    failures,
    output int                                    results_due
);
    import pft_pkg::*;

    typedef struct packed {
        logic [PRIME_W-1:0]   prime;
        logic [EXP_W-1:0]     exponent;
        logic [TOT_W-1:0]     totient;
        logic                 last;
        logic [IN_DATA_W-1:0] value;     // source value, for messages
    } factor_t;

    factor_t factors_due[$];
    int      fail_count = 0;

    assign failures = fail_count;

    // trial division: twos first, odd divisors while d*d <= rest,
    // leftover above two is a prime of its own
    task automatic predict_factors(input logic [IN_DATA_W-1:0] value);
        longint unsigned rest;
        longint unsigned trial;
        longint unsigned phi;
        longint unsigned term;
        int unsigned     mult;
        longint unsigned primes[$];
        int unsigned     powers[$];
        factor_t         item;
        int              n;
        int              k;
        int              j;
        rest = value;
        item.value = value;
        if (rest <= 1)
        begin
            // one and zero: a single empty result, totient equals the value
            item.prime    = '0;
            item.exponent = '0;
            item.totient  = TOT_W'(value);
            item.last     = 1'b1;
            factors_due.push_back(item);
        end
        else
        begin
            mult = 0;
            while ((rest & 64'd1) == 0)
            begin
                mult++;
                rest = rest >> 1;
            end
            if (mult != 0)
            begin
                primes.push_back(64'd2);
                powers.push_back(mult);
            end
            for (trial = 3; trial <= rest / trial; trial += 2)
            begin
                mult = 0;
                while (rest % trial == 0)
                begin
                    mult++;
                    rest = rest / trial;
                end
                if (mult != 0)
                begin
                    primes.push_back(trial);
                    powers.push_back(mult);
                end
            end
            if (rest > 2)
            begin
                primes.push_back(rest);
                powers.push_back(1);
            end
            // phi = product of p^(e-1) * (p-1)
            phi = 1;
            for (k = 0; k < primes.size(); k++)
            begin
                term = primes[k] - 1;
                for (j = 1; j < powers[k]; j++)
                    term = term * primes[k];
                phi = phi * term;
            end
            n = (primes.size() > MAX_RESULTS) ? MAX_RESULTS : primes.size();
            for (k = 0; k < n; k++)
            begin
                item.prime    = PRIME_W'(primes[k]);
                item.exponent = (powers[k] > EXP_MAX) ? EXP_MAX : EXP_W'(powers[k]);
                item.last     = (k == n - 1);
                if (!item.last)
                    item.totient = '0;
                else if (phi > TOT_MAX)
                    item.totient = TOT_MAX;
                else
                    item.totient = TOT_W'(phi);
                factors_due.push_back(item);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want,
                                   input logic [IN_DATA_W-1:0] value);
        fail_count++;
        if (fail_count <= 200)
            $display("[%0t] mismatch %s for value %0d: got %0d, expected %0d",
                     $time, what, value, got, want);
    endtask

    always @(posedge clk)
    begin
        factor_t want;
        if (rst_n)
        begin
            // results first so a value accepted on this edge never matches
            if (m_tvalid && m_tready)
            begin
                if (factors_due.size() == 0)
                    report_mismatch("unexpected result, prime", m_tdata[PRIME_W-1:0], 0, 0);
                else
                begin
                    want = factors_due.pop_front();
                    if (m_tdata[PRIME_W-1:0] !== want.prime)
                        report_mismatch("prime", m_tdata[PRIME_W-1:0], want.prime,
                                        want.value);
                    if (m_tdata[PRIME_W +: EXP_W] !== want.exponent)
                        report_mismatch("exponent", m_tdata[PRIME_W +: EXP_W],
                                        want.exponent, want.value);
                    if (m_tdata[PRIME_W+EXP_W +: TOT_W] !== want.totient)
                        report_mismatch("totient", m_tdata[PRIME_W+EXP_W +: TOT_W],
                                        want.totient, want.value);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last, want.value);
                end
            end
            if (s_tvalid && s_tready)
                predict_factors(s_tdata);
        end
        results_due <= factors_due.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for prime_factor_totient: directed corner values, then
// random values (mostly small or smooth, so trial division stays short),
// random gaps on the input side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import pft_pkg::*;

    localparam int RANDOM_ITEMS = 80;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;     // value[31:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // prime, exponent, totient, zero fill
    logic                  m_tlast;           // last
    int                    failures;
    int                    results_due;
    bit                    no_gaps  = 1'b0;   // set for stretches with no idling

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    prime_factor_totient #(
        .VALUE_WIDTH (IN_DATA_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pft_tb_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .results_due (results_due)
    );

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Cost is set by the second largest prime factor (repeats counted) or
    // the square root of the largest, so large values are products of
    // small factors and plain random values stay mostly below 2^20.
    function automatic logic [IN_DATA_W-1:0] pick_value();
        int              r;
        longint unsigned acc;
        longint unsigned q;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            acc = 1;
            repeat ($urandom_range(2, 14))
            begin
                q = $urandom_range(2, 97);
                if (acc * q <= 64'hFFFF_FFFF)
                    acc = acc * q;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                q = $urandom_range(2, 3000);
                if (acc * q <= 64'hFFFF_FFFF)
                    acc = acc * q;
            end
            return IN_DATA_W'(acc);
        end
        else if (r < 78)
            return $urandom_range(1, 65535);
        else if (r < 94)
            return $urandom_range(1, 1048575);
        else if (r < 96)
            return $urandom_range(1, 16777215);
        else
            return $urandom_range(1, 15);
    endfunction

    // one input transaction; valid stays high across back-to-back items
    task automatic send_value(input logic [IN_DATA_W-1:0] value, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the input off until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
    endtask

    // result side back-pressure
    initial
    begin
        int r;
        int len;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                m_tready <= 1'b1;
                len = $urandom_range(1, 8);
            end
            else if (r < 85)
            begin
                m_tready <= 1'b0;
                len = $urandom_range(1, 3);
            end
            else if (r < 95)
            begin
                m_tready <= 1'b0;
                len = $urandom_range(8, 40);
            end
            else
            begin
                m_tready <= 1'b1;
                len = $urandom_range(100, 300);
            end
            repeat (len) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one and zero, small primes and powers, nine primes,
        // saturated exponent range, all-ones and alternating bit patterns
        send_value(32'd1, pick_gap());
        send_value(32'd0, pick_gap());
        send_value(32'd2, pick_gap());
        send_value(32'd3, pick_gap());
        send_value(32'd4, pick_gap());
        send_value(32'd6, pick_gap());
        send_value(32'd12, pick_gap());
        send_value(32'd8633, pick_gap());           // 89 * 97
        send_value(32'd30030, pick_gap());
        send_value(32'd720720, pick_gap());
        send_value(32'd65521, pick_gap());          // prime, leftover path
        send_value(32'd1048573, pick_gap());
        send_value(32'd1018081, pick_gap());        // 1009 squared
        send_value(32'd9699690, pick_gap());
        send_value(32'd223092870, pick_gap());      // nine distinct primes
        send_value(32'd3486784401, pick_gap());     // 3^20
        send_value(32'h8000_0000, pick_gap());      // 2^31, exponent 31
        send_value(32'h5555_5555, pick_gap());
        send_value(32'hAAAA_AAAA, pick_gap());
        send_value(32'd4294901760, pick_gap());     // 2^16 * 65535
        send_value(32'hFFFF_FFFF, pick_gap());
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 16 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            send_value(pick_value(), pick_gap());
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (200) @(posedge clk);

        if (failures == 0 && results_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit, well above the slowest correct run
    initial
    begin
        #1_000_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
